// File: rtl/core/dik_pkg.sv
package dik_pkg;

  localparam int CoordW    = 24;
  localparam int PosW      = 25;
  localparam int LenW      = 23;
  localparam int TrigW     = 16;
  localparam int TrigShift = 15;
  localparam int ProdW     = LenW + 1 + TrigW;
  localparam int OffW      = ProdW - TrigShift;
  localparam int DiffW     = 26;
  localparam int SqW       = 2 * DiffW;
  localparam int RadSW     = SqW + 1;
  localparam int RadW      = 2 * LenW;
  localparam int RootW     = LenW;
  localparam int Lanes     = 3;
  localparam int CfgIdxW   = 2;

  typedef enum logic [CfgIdxW-1:0] {
    RegRodLength  = 2'd0,
    RegJointOff   = 2'd1,
    RegSinAngle   = 2'd2,
    RegCosAngle   = 2'd3
  } dik_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] z;
    logic                     unreachable;
  } dik_side_t;

endpackage

// File: rtl/core/dik_if.sv
interface dik_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [dik_pkg::CoordW-1:0]     target_x;
  logic signed [dik_pkg::CoordW-1:0]     target_y;
  logic signed [dik_pkg::CoordW-1:0]     target_z;
  modport source (output valid, target_x, target_y, target_z, input ready);
  modport sink   (input valid, target_x, target_y, target_z, output ready);
endinterface

interface dik_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [dik_pkg::PosW-1:0]       carriage_a;
  logic signed [dik_pkg::PosW-1:0]       carriage_b;
  logic signed [dik_pkg::PosW-1:0]       carriage_c;
  logic                                  unreachable;
  modport source (output valid, carriage_a, carriage_b, carriage_c, unreachable, input ready);
  modport sink   (input valid, carriage_a, carriage_b, carriage_c, unreachable, output ready);
endinterface

// File: rtl/core/dik_isqrt_pipe.sv
// three-lane floor square root, one result bit per stage
module dik_isqrt_pipe (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  in_valid_i,
  output logic                                                  in_ready_o,
  input  logic [dik_pkg::Lanes-1:0][dik_pkg::RadW-1:0]          rad_i,
  input  dik_pkg::dik_side_t                                    side_i,
  output logic                                                  out_valid_o,
  input  logic                                                  out_ready_i,
  output logic [dik_pkg::Lanes-1:0][dik_pkg::RootW-1:0]         root_o,
  output dik_pkg::dik_side_t                                    side_o
);

  localparam int NS = dik_pkg::RootW;
  localparam int RW = dik_pkg::RadW;
  localparam int NL = dik_pkg::Lanes;

  logic                                  vld_q  [NS];
  logic                                  rdy    [NS+1];
  logic [NL-1:0][RW-1:0]                 rem_q  [NS];
  logic [NL-1:0][dik_pkg::RootW-1:0]     root_q [NS];
  dik_pkg::dik_side_t                    side_q [NS];

  assign rdy[NS]     = out_ready_i;
  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NS-1];
  assign root_o      = root_q[NS-1];
  assign side_o      = side_q[NS-1];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int K = NS - 1 - s;
    logic                              vin;
    logic [NL-1:0][RW-1:0]             rem_in, rem_d;
    logic [NL-1:0][dik_pkg::RootW-1:0] root_in, root_d;
    dik_pkg::dik_side_t                side_in;

    if (s == 0) begin : g_first
      assign vin     = in_valid_i;
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vin     = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign side_in = side_q[s-1];
    end

    // (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
    always_comb begin
      logic [RW-1:0] trial;
      rem_d  = rem_in;
      root_d = root_in;
      for (int l = 0; l < NL; l++) begin
        trial = (RW'(root_in[l]) << (K + 1)) + (RW'(1) << (2 * K));
        if (rem_in[l] >= trial) begin
          rem_d[l]     = rem_in[l] - trial;
          root_d[l][K] = 1'b1;
        end
      end
    end

    assign rdy[s] = !vld_q[s] || rdy[s+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && vin) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        side_q[s] <= side_in;
      end
    end
  end

endmodule

// File: rtl/core/delta_inverse_kinematics_core.sv
// linear delta inverse kinematics: one (x, y, z) target item in, one item with the three
// carriage positions out. fully pipelined, one item per clock while output is ready; stages:
// five arithmetic stages (trig and rod products, trig rounding, joint offsets, squares,
// radicands), 23 square-root stages that resolve one root bit each, and the output register.
// every stage stalls only when the stage behind it is full, so bubbles are squeezed out.
// config is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must do so only while
// the pipe is empty, as the block does not check it. sin and cos are Q1.15, lengths and
// coordinates carry 8 fraction bits; any negative radicand sets unreachable, zero carriages.
module delta_inverse_kinematics_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dik_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [dik_pkg::LenW-1:0]        cfg_data_i,
  dik_in_if.sink                          target_i,
  dik_out_if.source                       result_o
);

  localparam int CW = dik_pkg::CoordW;
  localparam int DW = dik_pkg::DiffW;

  // config registers
  logic        [dik_pkg::LenW-1:0]  rod_q, joff_q;
  logic signed [dik_pkg::TrigW-1:0] sin_q, cos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rod_q  <= '0;
      joff_q <= '0;
      sin_q  <= '0;
      cos_q  <= 16'sh7FFF;
    end else if (cfg_we_i) begin
      case (dik_pkg::dik_reg_e'(cfg_idx_i))
        dik_pkg::RegRodLength: rod_q  <= cfg_data_i;
        dik_pkg::RegJointOff:  joff_q <= cfg_data_i;
        dik_pkg::RegSinAngle:  sin_q  <= cfg_data_i[dik_pkg::TrigW-1:0];
        dik_pkg::RegCosAngle:  cos_q  <= cfg_data_i[dik_pkg::TrigW-1:0];
        default: ;
      endcase
    end
  end

  logic signed [dik_pkg::LenW:0] joff_s;
  assign joff_s = $signed({1'b0, joff_q});

  // stage valids and per-stage advance
  logic v1_q, v2_q, v3_q, v4_q, v5_q, vo_q;
  logic r1, r2, r3, r4, r5, ro;
  logic sq_ready, sq_valid;

  assign ro = !vo_q || result_o.ready;
  assign r5 = !v5_q || sq_ready;
  assign r4 = !v4_q || r5;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign target_i.ready = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (r1) v1_q <= target_i.valid;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
      if (r5) v5_q <= v4_q;
      if (ro) vo_q <= sq_valid;
    end
  end

  // stage 1: capture target, trig and rod products
  logic signed [CW-1:0]                 x1_q, y1_q, z1_q;
  logic signed [dik_pkg::ProdW-1:0]     ps1_q, pc1_q;
  logic        [dik_pkg::RadW-1:0]      l2_1_q;

  always_ff @(posedge clk_i) begin
    if (r1 && target_i.valid) begin
      x1_q   <= target_i.target_x;
      y1_q   <= target_i.target_y;
      z1_q   <= target_i.target_z;
      ps1_q  <= joff_s * sin_q;
      pc1_q  <= joff_s * cos_q;
      l2_1_q <= rod_q * rod_q;
    end
  end

  // stage 2: round trig products back to length format (add half, then shift)
  logic signed [CW-1:0]                 x2_q, y2_q, z2_q;
  logic signed [dik_pkg::OffW-1:0]      ds2_q, dc2_q;
  logic        [dik_pkg::RadW-1:0]      l2_2_q;
  localparam logic signed [dik_pkg::ProdW-1:0] TrigHalf =
    dik_pkg::ProdW'(1) <<< (dik_pkg::TrigShift - 1);

  always_ff @(posedge clk_i) begin
    if (r2 && v1_q) begin
      x2_q   <= x1_q;
      y2_q   <= y1_q;
      z2_q   <= z1_q;
      ds2_q  <= dik_pkg::OffW'((ps1_q + TrigHalf) >>> dik_pkg::TrigShift);
      dc2_q  <= dik_pkg::OffW'((pc1_q + TrigHalf) >>> dik_pkg::TrigShift);
      l2_2_q <= l2_1_q;
    end
  end

  // stage 3: joint minus effector for each tower (towers b and c share dy)
  logic signed [DW-1:0]            dax3_q, day3_q, dbx3_q, dby3_q, dcx3_q;
  logic signed [CW-1:0]            z3_q;
  logic        [dik_pkg::RadW-1:0] l2_3_q;

  always_ff @(posedge clk_i) begin
    if (r3 && v2_q) begin
      dax3_q <= -DW'(x2_q);
      day3_q <= DW'(joff_s) - DW'(y2_q);
      dbx3_q <= -DW'(ds2_q) - DW'(x2_q);
      dby3_q <= -DW'(dc2_q) - DW'(y2_q);
      dcx3_q <= DW'(ds2_q) - DW'(x2_q);
      z3_q   <= z2_q;
      l2_3_q <= l2_2_q;
    end
  end

  // stage 4: squares
  logic signed [dik_pkg::SqW-1:0]  sax4_q, say4_q, sbx4_q, sby4_q, scx4_q;
  logic signed [CW-1:0]            z4_q;
  logic        [dik_pkg::RadW-1:0] l2_4_q;

  always_ff @(posedge clk_i) begin
    if (r4 && v3_q) begin
      sax4_q <= dax3_q * dax3_q;
      say4_q <= day3_q * day3_q;
      sbx4_q <= dbx3_q * dbx3_q;
      sby4_q <= dby3_q * dby3_q;
      scx4_q <= dcx3_q * dcx3_q;
      z4_q   <= z3_q;
      l2_4_q <= l2_3_q;
    end
  end

  // stage 5: radicands
  localparam int SW = dik_pkg::RadSW;
  logic signed [SW-1:0] ra5_q, rb5_q, rc5_q, l2s;
  logic signed [CW-1:0] z5_q;

  assign l2s = $signed({{(SW - dik_pkg::RadW){1'b0}}, l2_4_q});

  always_ff @(posedge clk_i) begin
    if (r5 && v4_q) begin
      ra5_q <= l2s - SW'(sax4_q) - SW'(say4_q);
      rb5_q <= l2s - SW'(sbx4_q) - SW'(sby4_q);
      rc5_q <= l2s - SW'(scx4_q) - SW'(sby4_q);
      z5_q  <= z4_q;
    end
  end

  // a non-negative radicand never exceeds rod length squared, so it fits the root input
  logic                                                 neg5;
  logic [dik_pkg::Lanes-1:0][dik_pkg::RadW-1:0]         sq_rad;
  logic [dik_pkg::Lanes-1:0][dik_pkg::RootW-1:0]        sq_root;
  dik_pkg::dik_side_t                                   sq_side_in, sq_side_out;

  assign neg5 = ra5_q[SW-1] || rb5_q[SW-1] || rc5_q[SW-1];

  always_comb begin
    sq_rad = '0;
    if (!neg5) begin
      sq_rad[0] = ra5_q[dik_pkg::RadW-1:0];
      sq_rad[1] = rb5_q[dik_pkg::RadW-1:0];
      sq_rad[2] = rc5_q[dik_pkg::RadW-1:0];
    end
    sq_side_in.z           = z5_q;
    sq_side_in.unreachable = neg5;
  end

  dik_isqrt_pipe u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v5_q),
    .in_ready_o  (sq_ready),
    .rad_i       (sq_rad),
    .side_i      (sq_side_in),
    .out_valid_o (sq_valid),
    .out_ready_i (ro),
    .root_o      (sq_root),
    .side_o      (sq_side_out)
  );

  // output register: root plus z, zeroed when unreachable
  logic signed [dik_pkg::PosW-1:0] ca_q, cb_q, cc_q;
  logic                            unr_q;

  function automatic logic signed [dik_pkg::PosW-1:0] carriage(
    input logic [dik_pkg::RootW-1:0] root,
    input logic signed [CW-1:0]      z
  );
    return $signed({{(dik_pkg::PosW - dik_pkg::RootW){1'b0}}, root}) + dik_pkg::PosW'(z);
  endfunction

  always_ff @(posedge clk_i) begin
    if (ro && sq_valid) begin
      unr_q <= sq_side_out.unreachable;
      if (sq_side_out.unreachable) begin
        ca_q <= '0;
        cb_q <= '0;
        cc_q <= '0;
      end else begin
        ca_q <= carriage(sq_root[0], sq_side_out.z);
        cb_q <= carriage(sq_root[1], sq_side_out.z);
        cc_q <= carriage(sq_root[2], sq_side_out.z);
      end
    end
  end

  assign result_o.valid       = vo_q;
  assign result_o.carriage_a  = ca_q;
  assign result_o.carriage_b  = cb_q;
  assign result_o.carriage_c  = cc_q;
  assign result_o.unreachable = unr_q;

  // unreachable items carry zero positions
  a_unreach_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && unr_q) |-> (ca_q == '0 && cb_q == '0 && cc_q == '0))
    else $error("unreachable item with nonzero carriage");

  // input back-pressure only when the whole pipe is full and the output is stalled
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !target_i.ready |-> (v1_q && v5_q && vo_q && !result_o.ready))
    else $error("input stalled with room in the pipe");

  // an accepted item lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (target_i.valid && target_i.ready) |=> v1_q)
    else $error("accepted item lost at stage one");

endmodule

// File: tb/delta_inverse_kinematics_core_tb.sv
module delta_inverse_kinematics_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // one set of carriage positions as the block should give it
  typedef struct {
    logic signed [dik_pkg::PosW-1:0] a;
    logic signed [dik_pkg::PosW-1:0] b;
    logic signed [dik_pkg::PosW-1:0] c;
    logic                            unr;
  } carriage_set_t;

  // tracks the register file and the carriage sets still owed by the pipe
  class carriage_tracker;
    logic [dik_pkg::LenW-1:0]         rod;
    logic [dik_pkg::LenW-1:0]         offset;
    logic signed [dik_pkg::TrigW-1:0] sine;
    logic signed [dik_pkg::TrigW-1:0] cosine;
    carriage_set_t                    owed[$];

    function new();
      rod    = '0;
      offset = '0;
      sine   = '0;
      cosine = 16'sd32767;
    endfunction

    function void set_reg(dik_pkg::dik_reg_e idx, logic [dik_pkg::LenW-1:0] val);
      case (idx)
        dik_pkg::RegRodLength: rod    = val;
        dik_pkg::RegJointOff:  offset = val;
        dik_pkg::RegSinAngle:  sine   = val[dik_pkg::TrigW-1:0];
        dik_pkg::RegCosAngle:  cosine = val[dik_pkg::TrigW-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // trig products rounded back to 8 fraction bits, half added before the shift
    function longint trig_scale(longint d, longint t);
      return (d * t + 64'sd16384) >>> dik_pkg::TrigShift;
    endfunction

    function void note_target(logic signed [dik_pkg::CoordW-1:0] x,
                              logic signed [dik_pkg::CoordW-1:0] y,
                              logic signed [dik_pkg::CoordW-1:0] z);
      longint lx, ly, lz, d, ds, dc, l2, ra, rb, rc;
      carriage_set_t e;
      lx = x;
      ly = y;
      lz = z;
      d  = longint'(offset);
      ds = trig_scale(d, longint'(sine));
      dc = trig_scale(d, longint'(cosine));
      l2 = longint'(rod) * longint'(rod);
      ra = l2 - lx * lx - (d - ly) * (d - ly);
      rb = l2 - (-ds - lx) * (-ds - lx) - (-dc - ly) * (-dc - ly);
      rc = l2 - (ds - lx) * (ds - lx) - (-dc - ly) * (-dc - ly);
      if (ra < 0 || rb < 0 || rc < 0) begin
        e.a = '0;
        e.b = '0;
        e.c = '0;
        e.unr = 1'b1;
      end else begin
        e.a = dik_pkg::PosW'(longint'(root_floor(ra)) + lz);
        e.b = dik_pkg::PosW'(longint'(root_floor(rb)) + lz);
        e.c = dik_pkg::PosW'(longint'(root_floor(rc)) + lz);
        e.unr = 1'b0;
      end
      owed.push_back(e);
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // empty string when the item matches the oldest owed set
    function string check_carriages(carriage_set_t got);
      carriage_set_t e;
      string msg;
      if (owed.size() == 0) return "result item with nothing owed";
      e = owed.pop_front();
      msg = "";
      if (got.a !== e.a) msg = {msg, $sformatf(" a %0d/%0d", got.a, e.a)};
      if (got.b !== e.b) msg = {msg, $sformatf(" b %0d/%0d", got.b, e.b)};
      if (got.c !== e.c) msg = {msg, $sformatf(" c %0d/%0d", got.c, e.c)};
      if (got.unr !== e.unr) msg = {msg, $sformatf(" unreachable %0b/%0b", got.unr, e.unr)};
      if (msg != "") msg = {"got/exp:", msg};
      return msg;
    endfunction
  endclass

  localparam int WatchLimit = 3000;
  localparam int DrainWait  = 40;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [dik_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [dik_pkg::LenW-1:0]    cfg_data_i;

  dik_in_if  tgt ();
  dik_out_if res ();

  delta_inverse_kinematics_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .target_i   (tgt),
    .result_o   (res)
  );

  carriage_tracker tracker = new();
  int errors    = 0;
  int send_idle = 0;   // percent of cycles the sender holds back
  int recv_idle = 0;   // percent of cycles the receiver stalls
  int quiet     = 0;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  task automatic report(string msg);
    errors++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // receiver side: check on the edge, then pick the next ready
  always @(posedge clk_i) begin
    carriage_set_t got;
    string msg;
    if (res.valid && res.ready) begin
      got.a   = res.carriage_a;
      got.b   = res.carriage_b;
      got.c   = res.carriage_c;
      got.unr = res.unreachable;
      msg = tracker.check_carriages(got);
      if (msg != "") report(msg);
    end
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((tgt.valid && tgt.ready) || (res.valid && res.ready)) begin
      quiet <= 0;
    end else if (quiet >= WatchLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_target(logic signed [dik_pkg::CoordW-1:0] x,
                             logic signed [dik_pkg::CoordW-1:0] y,
                             logic signed [dik_pkg::CoordW-1:0] z);
    while ($urandom_range(99) < send_idle) begin
      tgt.valid <= 1'b0;
      @(posedge clk_i);
    end
    tgt.valid    <= 1'b1;
    tgt.target_x <= x;
    tgt.target_y <= y;
    tgt.target_z <= z;
    do @(posedge clk_i); while (!tgt.ready);
    tracker.note_target(x, y, z);
  endtask

  // drop valid and wait for every owed item, then let the pipe settle
  task automatic drain();
    tgt.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(dik_pkg::dik_reg_e idx, logic [dik_pkg::LenW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_reg(idx, val);
  endtask

  task automatic load_setting(logic [dik_pkg::LenW-1:0] rod, logic [dik_pkg::LenW-1:0] off,
                              logic signed [dik_pkg::TrigW-1:0] s,
                              logic signed [dik_pkg::TrigW-1:0] c);
    write_reg(dik_pkg::RegRodLength, rod);
    write_reg(dik_pkg::RegJointOff, off);
    write_reg(dik_pkg::RegSinAngle, dik_pkg::LenW'($unsigned(s)));
    write_reg(dik_pkg::RegCosAngle, dik_pkg::LenW'($unsigned(c)));
    @(posedge clk_i);
  endtask

  function automatic logic signed [dik_pkg::CoordW-1:0] any_coord();
    return dik_pkg::CoordW'($urandom);
  endfunction

  // coordinate inside +/- lim so most targets are reachable
  function automatic logic signed [dik_pkg::CoordW-1:0] near_coord(int lim);
    return dik_pkg::CoordW'(int'($urandom_range(2 * lim)) - lim);
  endfunction

  // settings: rod, offset, sin, cos
  logic [dik_pkg::LenW-1:0]         set_rod[6] = '{23'd51200, 23'h7fffff, 23'h7fffff,
                                                   23'd100000, 23'd1000, 23'd4000000};
  logic [dik_pkg::LenW-1:0]         set_off[6] = '{23'd12800, 23'h7fffff, 23'd0,
                                                   23'h7fffff, 23'd300, 23'd2000000};
  logic signed [dik_pkg::TrigW-1:0] set_sin[6] = '{16'sd28378, -16'sd32768, 16'sd32767,
                                                   16'sd0, 16'sd12345, -16'sd28378};
  logic signed [dik_pkg::TrigW-1:0] set_cos[6] = '{16'sd16384, 16'sd32767, -16'sd32768,
                                                   -16'sd32768, -16'sd20000, -16'sd16384};

  initial begin
    int lim;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = dik_pkg::RegRodLength;
    cfg_data_i = '0;
    tgt.valid    = 1'b0;
    tgt.target_x = '0;
    tgt.target_y = '0;
    tgt.target_z = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // reset registers: zero rod and offset, only the origin has a zero radicand
    send_target(0, 0, 24'sh7fffff);
    send_target(0, 0, -24'sh800000);
    send_target(0, 0, 0);
    send_target(1, 0, 5);
    send_target(-24'sh800000, 24'sh7fffff, 0);
    drain();

    // typical geometry: zero radicand, far targets, field extremes
    load_setting(set_rod[0], set_off[0], set_sin[0], set_cos[0]);
    send_target(0, 23'sd51200 + 23'sd12800, 100);      // radicand of tower a exactly zero
    send_target(0, 0, 0);
    send_target(0, 0, 24'sh7fffff);
    send_target(0, 0, -24'sh800000);
    send_target(24'sh7fffff, 0, 0);
    send_target(-24'sh800000, -24'sh800000, 24'sh7fffff);
    send_target(1000, -2000, -300);
    drain();

    // widest geometry with the largest values
    load_setting(set_rod[1], set_off[1], set_sin[1], set_cos[1]);
    send_target(0, 0, 24'sh7fffff);
    send_target(0, 0, -24'sh800000);
    send_target(24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
    send_target(-24'sh800000, -24'sh800000, -24'sh800000);
    send_target(24'sh7fffff, -24'sh800000, 24'sh7fffff);
    drain();

    // random phases, one per setting, idling pattern cycles through three modes
    for (int p = 0; p < 6; p++) begin
      load_setting(set_rod[p], set_off[p], set_sin[p], set_cos[p]);
      case (p / 2)
        0: begin
          send_idle = 16;
          recv_idle = 69;
        end
        1: begin
          send_idle = 69;
          recv_idle = 16;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      lim = (set_rod[p] > 23'd16) ? int'(set_rod[p]) / 2 : 8;
      for (int i = 0; i < 150; i++) begin
        if ($urandom_range(99) < 75) begin
          send_target(near_coord(lim), near_coord(lim), any_coord());
        end else begin
          send_target(any_coord(), any_coord(), any_coord());
        end
        // hold off mid-phase until the pipe is empty
        if (i == 75) drain();
      end
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/core/dik_pkg.sv
rtl/core/dik_if.sv
rtl/core/dik_isqrt_pipe.sv
rtl/core/delta_inverse_kinematics_core.sv
tb/delta_inverse_kinematics_core_tb.sv
